>>> hdl/wsfr_pkg.sv
// Shared types and constants for the websocket frame receiver.
// Used by wsfr_front, wsfr_queue, wsfr_back and websocket_frame_receiver.
// No dependencies.
package wsfr_pkg;

   localparam int LENGTH_BITS = 64;

   // Largest length that LENGTH_BITS bits can express, in a 64-bit word
   localparam logic [63:0] LENGTH_CAP = ((64'd1 << (LENGTH_BITS - 1)) << 1) - 64'd1;
   localparam logic [63:0] MAX_LEN_RESET = 64'd128 << 20;
   localparam logic [63:0] LIMIT_RESET =
      (MAX_LEN_RESET > LENGTH_CAP) ? LENGTH_CAP : MAX_LEN_RESET;

   // Register byte address
   localparam logic [3:0] ADDR_MAX_LEN = 4'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_MARKER  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Frame classes
   localparam logic [1:0] CLS_DATA  = 2'd0;
   localparam logic [1:0] CLS_PING  = 2'd1;
   localparam logic [1:0] CLS_CLOSE = 2'd2;
   localparam logic [1:0] CLS_PONG  = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_STRAY     = 3'd1;
   localparam logic [2:0] ERR_MID_FRAG  = 3'd2;
   localparam logic [2:0] ERR_OPCODE    = 3'd3;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

   // Opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Length codes in the second header byte
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Work item handed from the parser to the output side
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [1:0] frame_class;
      logic       message_type;
      logic       last_of_frame;
      logic       last_of_message;
      logic [2:0] error_code;
   } wsfr_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } wsfr_qstat_type;

endpackage

>>> hdl/websocket_frame_receiver.sv
// Top level of the websocket frame receiver: register port, parser, queue
// and output side. Depends on wsfr_pkg, wsfr_front, wsfr_queue, wsfr_back.
//
//   channel  direction  handshake                        payload
//   req      in         req_valid / req_stall            req_in_byte
//   rsp      out        rsp_valid / rsp_stall            kind, data_byte, class, flags, error
//   csr      in/out     csr_psel / csr_penable / pready  paddr, pwdata, prdata (64 bit)
//
// One byte is taken every cycle while req_stall is low; each result is registered.
// The parser takes a byte while the output register still holds an untaken
// result; req_stall rises only when the two-entry queue between them is full.
// Reset is synchronous and returns the parser to the first header byte.
// After a close frame or an error further bytes are taken and dropped.
module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_frame_class,
   output logic        rsp_message_type,
   output logic        rsp_last_of_frame,
   output logic        rsp_last_of_message,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0]    max_len_ff, max_len_in;
   logic [63:0]    limit_ff, limit_in;
   logic           csr_write;
   logic           accept;
   logic           push;
   wsfr_entry_type push_entry;
   logic           pop;
   wsfr_entry_type pop_entry;
   wsfr_qstat_type qstat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[3] == ADDR_MAX_LEN[3]);
   assign csr_prdata = (csr_paddr[3] == ADDR_MAX_LEN[3]) ? max_len_ff : 64'd0;

   always_comb begin
      max_len_in = max_len_ff;
      limit_in   = limit_ff;
      if (csr_write) begin
         max_len_in = csr_pwdata;
         limit_in   = (csr_pwdata > LENGTH_CAP) ? LENGTH_CAP : csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         limit_ff   <= LIMIT_RESET;
      end else begin
         max_len_ff <= max_len_in;
         limit_ff   <= limit_in;
      end
   end

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   wsfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .length_limit (limit_ff),
      .push         (push),
      .push_entry   (push_entry)
   );

   wsfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (qstat)
   );

   wsfr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (qstat.valid),
      .q_entry             (pop_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_class     (rsp_frame_class),
      .rsp_message_type    (rsp_message_type),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_error_code      (rsp_error_code)
   );

   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR) |->
         rsp_last_of_frame && (rsp_error_code != ERR_NONE) && !rsp_last_of_message)
      else $error("error result without frame end or code");

   a_no_code_on_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_ERROR) |-> (rsp_error_code == ERR_NONE))
      else $error("error code on a non-error result");

   a_msg_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_message |->
         rsp_last_of_frame && (rsp_frame_class == CLS_DATA))
      else $error("message end outside a data frame end");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("work item pushed into a full queue");

endmodule

>>> hdl/wsfr_front.sv
// Header parser: accepts stream bytes, tracks frame and message state and
// emits one work item per result. Depends on wsfr_pkg.
module wsfr_front
   import wsfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     in_byte,
   input  logic [63:0]    length_limit,
   output logic           push,
   output wsfr_entry_type push_entry
);

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_MASK = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] frame_length_ff, frame_length_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_phase_ff, mask_phase_in;
   logic        final_ff, final_in;
   logic        masked_ff, masked_in;
   logic [3:0]  frame_op_ff, frame_op_in;
   logic        in_fragment_ff, in_fragment_in;
   logic        msg_type_ff, msg_type_in;
   logic        halted_ff, halted_in;
   logic [1:0]  frame_cls_ff, frame_cls_in;

   logic        hdr_done;
   logic [63:0] hdr_len;
   logic [2:0]  err;
   logic [7:0]  key_byte;
   logic        last;
   logic [6:0]  len7;

   always_comb begin
      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      frame_length_in = frame_length_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      mask_phase_in   = mask_phase_ff;
      final_in        = final_ff;
      masked_in       = masked_ff;
      frame_op_in     = frame_op_ff;
      in_fragment_in  = in_fragment_ff;
      msg_type_in     = msg_type_ff;
      halted_in       = halted_ff;
      frame_cls_in    = frame_cls_ff;
      hdr_done        = 1'b0;
      hdr_len         = frame_length_ff;
      err             = ERR_NONE;
      last            = 1'b0;
      len7            = in_byte[6:0];
      push            = 1'b0;
      push_entry      = '0;

      case (mask_phase_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase

      if (accept && !halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               final_in    = in_byte[7];
               frame_op_in = in_byte[3:0];
               phase_in    = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in       = in_byte[7];
               mask_key_in     = '0;
               frame_length_in = '0;
               if (len7 == LEN_EXT16) begin
                  ext_left_in = 4'd2;
                  phase_in    = PH_EXT;
               end else if (len7 == LEN_EXT64) begin
                  ext_left_in = 4'd8;
                  phase_in    = PH_EXT;
               end else begin
                  frame_length_in = {57'd0, len7};
                  hdr_len         = {57'd0, len7};
                  if (in_byte[7]) begin
                     ext_left_in = 4'd4;
                     phase_in    = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               frame_length_in = {frame_length_ff[55:0], in_byte};
               hdr_len         = {frame_length_ff[55:0], in_byte};
               ext_left_in     = ext_left_ff - 4'd1;
               if (ext_left_ff == 4'd1) begin
                  if (masked_ff) begin
                     ext_left_in = 4'd4;
                     phase_in    = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_MASK: begin
               mask_key_in = {mask_key_ff[23:0], in_byte};
               ext_left_in = ext_left_ff - 4'd1;
               if (ext_left_ff == 4'd1) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAY: begin
               last            = (payload_left_ff == 64'd1);
               mask_phase_in   = mask_phase_ff + 2'd1;
               payload_left_in = payload_left_ff - 64'd1;
               if (last) begin
                  phase_in = PH_HDR0;
               end
               if (frame_cls_ff != CLS_PONG) begin
                  push                     = 1'b1;
                  push_entry.kind          = KIND_PAYLOAD;
                  push_entry.raw_byte      = in_byte;
                  push_entry.key_byte      = key_byte;
                  push_entry.frame_class   = frame_cls_ff;
                  push_entry.last_of_frame = last;
                  if (frame_cls_ff == CLS_DATA) begin
                     push_entry.message_type    = msg_type_ff;
                     push_entry.last_of_message = last & final_ff;
                  end
                  if (frame_cls_ff == CLS_CLOSE && last) begin
                     halted_in = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // Resolve the finished header: length check first, then opcode
         if (hdr_done) begin
            if (hdr_len > length_limit) begin
               err = ERR_TOO_LARGE;
            end else begin
               case (frame_op_ff)
                  OP_PING:  frame_cls_in = CLS_PING;
                  OP_PONG:  frame_cls_in = CLS_PONG;
                  OP_CLOSE: frame_cls_in = CLS_CLOSE;
                  OP_CONT: begin
                     if (!in_fragment_ff) begin
                        err = ERR_STRAY;
                     end else begin
                        frame_cls_in   = CLS_DATA;
                        in_fragment_in = !final_ff;
                     end
                  end
                  OP_TEXT, OP_BINARY: begin
                     if (in_fragment_ff) begin
                        err = ERR_MID_FRAG;
                     end else begin
                        frame_cls_in   = CLS_DATA;
                        msg_type_in    = frame_op_ff[1];
                        in_fragment_in = !final_ff;
                     end
                  end
                  default: err = ERR_OPCODE;
               endcase
            end

            if (err != ERR_NONE) begin
               halted_in                = 1'b1;
               phase_in                 = PH_HDR0;
               push                     = 1'b1;
               push_entry.kind          = KIND_ERROR;
               push_entry.last_of_frame = 1'b1;
               push_entry.error_code    = err;
            end else begin
               mask_phase_in   = 2'd0;
               payload_left_in = hdr_len;
               if (hdr_len != 64'd0) begin
                  phase_in = PH_PAY;
               end else begin
                  phase_in = PH_HDR0;
                  if (frame_cls_in != CLS_PONG) begin
                     push                     = 1'b1;
                     push_entry.kind          = KIND_MARKER;
                     push_entry.frame_class   = frame_cls_in;
                     push_entry.last_of_frame = 1'b1;
                     if (frame_cls_in == CLS_DATA) begin
                        push_entry.message_type    = msg_type_in;
                        push_entry.last_of_message = final_ff;
                     end
                     if (frame_cls_in == CLS_CLOSE) begin
                        halted_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         ext_left_ff     <= '0;
         frame_length_ff <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         mask_phase_ff   <= '0;
         final_ff        <= 1'b0;
         masked_ff       <= 1'b0;
         frame_op_ff     <= '0;
         in_fragment_ff  <= 1'b0;
         msg_type_ff     <= 1'b0;
         halted_ff       <= 1'b0;
         frame_cls_ff    <= CLS_DATA;
      end else begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         frame_length_ff <= frame_length_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         mask_phase_ff   <= mask_phase_in;
         final_ff        <= final_in;
         masked_ff       <= masked_in;
         frame_op_ff     <= frame_op_in;
         in_fragment_ff  <= in_fragment_in;
         msg_type_ff     <= msg_type_in;
         halted_ff       <= halted_in;
         frame_cls_ff    <= frame_cls_in;
      end
   end

endmodule

>>> hdl/wsfr_queue.sv
// Short queue of work items between the parser and the output side.
// Depends on wsfr_pkg.
module wsfr_queue
   import wsfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  wsfr_entry_type push_entry,
   input  logic           pop,
   output wsfr_entry_type pop_entry,
   output wsfr_qstat_type status
);

   wsfr_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_pop;

   assign do_pop       = pop && (count_ff != '0);
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/wsfr_back.sv
// Output side: unmasks payload bytes and holds the result register.
// Depends on wsfr_pkg.
module wsfr_back
   import wsfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  wsfr_entry_type q_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [1:0]     rsp_kind,
   output logic [7:0]     rsp_data_byte,
   output logic [1:0]     rsp_frame_class,
   output logic           rsp_message_type,
   output logic           rsp_last_of_frame,
   output logic           rsp_last_of_message,
   output logic [2:0]     rsp_error_code
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic [1:0] cls_ff;
   logic       mt_ff;
   logic       lf_ff;
   logic       lm_ff;
   logic [2:0] err_ff;

   // Refill the result register when it is empty or its transfer completes
   assign pop = q_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= q_entry.kind;
         data_ff <= q_entry.raw_byte ^ q_entry.key_byte;
         cls_ff  <= q_entry.frame_class;
         mt_ff   <= q_entry.message_type;
         lf_ff   <= q_entry.last_of_frame;
         lm_ff   <= q_entry.last_of_message;
         err_ff  <= q_entry.error_code;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_data_byte       = data_ff;
   assign rsp_frame_class     = cls_ff;
   assign rsp_message_type    = mt_ff;
   assign rsp_last_of_frame   = lf_ff;
   assign rsp_last_of_message = lm_ff;
   assign rsp_error_code      = err_ff;

endmodule

>>> tb/websocket_frame_receiver_tb.sv
// Self-checking testbench for websocket_frame_receiver: random framed byte streams in,
// deframed payload, markers and errors checked against a scoreboard with its own deframer.
// Depends on wsfr_pkg and the websocket_frame_receiver RTL.
`timescale 1ns / 1ps

module websocket_frame_receiver_tb
   import wsfr_pkg::*;
();

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         HOLD_CYCLES    = 300;

   typedef enum logic [2:0] {P_HDR0, P_HDR1, P_EXT, P_MASK, P_PAY} parse_phase_type;
   typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_type;
   typedef enum int {END_CLOSE, END_STRAY, END_MID_FRAG, END_OPCODE, END_TOO_LARGE}
      end_kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] fclass;
      logic       mtype;
      logic       lof;
      logic       lom;
      logic [2:0] err;
   } deframed_type;

   class frame_scoreboard;
      logic [63:0]     length_limit;
      parse_phase_type phase;
      logic [3:0]      hdr_left;
      logic [63:0]     frame_len;
      logic [63:0]     pay_left;
      logic [31:0]     key;
      logic [1:0]      key_idx;
      logic            fin;
      logic            masked;
      logic            open_msg;
      logic            msg_bin;
      logic            halted;
      logic [3:0]      opcode;
      logic [1:0]      fclass;
      deframed_type    due_items[$];
      int unsigned     faults;
      int unsigned     results;
      int unsigned     payload_seen;
      int unsigned     markers_seen;
      int unsigned     errors_seen;

      function new();
         set_limit(MAX_LEN_RESET);
         phase = P_HDR0;
         hdr_left = 0;
         frame_len = 0;
         pay_left = 0;
         key = 0;
         key_idx = 0;
         fin = 0;
         masked = 0;
         open_msg = 0;
         msg_bin = 0;
         halted = 0;
         opcode = OP_CONT;
         fclass = CLS_DATA;
         faults = 0;
         results = 0;
         payload_seen = 0;
         markers_seen = 0;
         errors_seen = 0;
      endfunction

      function void set_limit(logic [63:0] v);
         length_limit = (v < LENGTH_CAP) ? v : LENGTH_CAP;
      endfunction

      function int pending();
         return due_items.size();
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] fc, logic mt,
                         logic lof, logic lom, logic [2:0] err);
         deframed_type r;
         r.kind = kind;
         r.data = data;
         r.fclass = fc;
         r.mtype = mt;
         r.lof = lof;
         r.lom = lom;
         r.err = err;
         due_items = {due_items, r};
      endfunction

      // Length is checked ahead of the opcode
      function void finish_header();
         logic [2:0] err;
         err = ERR_NONE;
         if (frame_len > length_limit) err = ERR_TOO_LARGE;
         else begin
            case (opcode)
               OP_PING:  fclass = CLS_PING;
               OP_PONG:  fclass = CLS_PONG;
               OP_CLOSE: fclass = CLS_CLOSE;
               OP_CONT: begin
                  if (!open_msg) err = ERR_STRAY;
                  else begin
                     fclass = CLS_DATA;
                     open_msg = !fin;
                  end
               end
               OP_TEXT, OP_BINARY: begin
                  if (open_msg) err = ERR_MID_FRAG;
                  else begin
                     fclass = CLS_DATA;
                     msg_bin = (opcode == OP_BINARY);
                     open_msg = !fin;
                  end
               end
               default: err = ERR_OPCODE;
            endcase
         end
         if (err != ERR_NONE) begin
            halted = 1;
            phase = P_HDR0;
            emit(KIND_ERROR, 8'h00, CLS_DATA, 1'b0, 1'b1, 1'b0, err);
            return;
         end
         key_idx = 0;
         pay_left = frame_len;
         if (frame_len != 0) begin
            phase = P_PAY;
            return;
         end
         phase = P_HDR0;
         if (fclass == CLS_PONG) return;
         if (fclass == CLS_CLOSE) halted = 1;
         if (fclass == CLS_DATA) emit(KIND_MARKER, 8'h00, CLS_DATA, msg_bin, 1'b1, fin, ERR_NONE);
         else emit(KIND_MARKER, 8'h00, fclass, 1'b0, 1'b1, 1'b0, ERR_NONE);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] d;
         logic       at_end;
         if (halted) return;
         case (phase)
            P_HDR0: begin
               fin = b[7];
               opcode = b[3:0];
               phase = P_HDR1;
            end
            P_HDR1: begin
               masked = b[7];
               key = 0;
               frame_len = 0;
               if (b[6:0] == LEN_EXT16) begin
                  hdr_left = 2;
                  phase = P_EXT;
               end else if (b[6:0] == LEN_EXT64) begin
                  hdr_left = 8;
                  phase = P_EXT;
               end else begin
                  frame_len = {57'd0, b[6:0]};
                  if (masked) begin
                     hdr_left = 4;
                     phase = P_MASK;
                  end else finish_header();
               end
            end
            P_EXT: begin
               frame_len = {frame_len[55:0], b};
               hdr_left--;
               if (hdr_left == 0) begin
                  if (masked) begin
                     hdr_left = 4;
                     phase = P_MASK;
                  end else finish_header();
               end
            end
            P_MASK: begin
               key = {key[23:0], b};
               hdr_left--;
               if (hdr_left == 0) finish_header();
            end
            P_PAY: begin
               d = b ^ key[8 * (3 - key_idx) +: 8];
               key_idx++;
               pay_left--;
               at_end = (pay_left == 0);
               if (at_end) phase = P_HDR0;
               if (fclass == CLS_PONG) return;
               if (fclass == CLS_CLOSE && at_end) halted = 1;
               if (fclass == CLS_DATA)
                  emit(KIND_PAYLOAD, d, CLS_DATA, msg_bin, at_end, at_end & fin, ERR_NONE);
               else emit(KIND_PAYLOAD, d, fclass, 1'b0, at_end, 1'b0, ERR_NONE);
            end
            default: phase = P_HDR0;
         endcase
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            faults++;
         end
      endfunction

      function void check_result(deframed_type got);
         deframed_type want;
         if (due_items.size() == 0) begin
            $error("result with none outstanding: kind %0d data %0d error_code %0d",
                   got.kind, got.data, got.err);
            faults++;
            return;
         end
         want = due_items.pop_front();
         results++;
         if (want.kind == KIND_PAYLOAD) payload_seen++;
         else if (want.kind == KIND_MARKER) markers_seen++;
         else errors_seen++;
         compare_field("kind", want.kind, got.kind);
         compare_field("data_byte", want.data, got.data);
         compare_field("frame_class", want.fclass, got.fclass);
         compare_field("message_type", want.mtype, got.mtype);
         compare_field("last_of_frame", want.lof, got.lof);
         compare_field("last_of_message", want.lom, got.lom);
         compare_field("error_code", want.err, got.err);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_frame_class;
   logic        rsp_message_type;
   logic        rsp_last_of_frame;
   logic        rsp_last_of_message;
   logic [2:0]  rsp_error_code;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard sb;
   deframed_type    seen;
   end_kind_type    ending;
   logic [63:0]     limit_now;
   int unsigned     bytes_sent;
   int unsigned     quiet_cycles = 0;
   int unsigned     limit_writes;
   bit              no_gaps;
   bit              hold_req;
   bit              holding;

   websocket_frame_receiver u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_class     (rsp_frame_class),
      .rsp_message_type    (rsp_message_type),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_error_code      (rsp_error_code),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #2 clock = ~clock;

   // Both transfers of one edge are seen here, input first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_data_byte, rsp_frame_class, rsp_message_type,
                    rsp_last_of_frame, rsp_last_of_message, rsp_error_code};
            sb.check_result(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("websocket_frame_receiver_tb failed");
            $finish;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_payload();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [63:0] pick_len();
      int unsigned r;
      logic [63:0] len;
      r = $urandom_range(0, 99);
      if (r < 25) len = 0;
      else if (r < 80) len = 64'($urandom_range(1, 16));
      else if (r < 95) len = 64'($urandom_range(17, 140));
      else len = 64'($urandom_range(141, 600));
      if (len > limit_now) len = limit_now;
      return len;
   endfunction

   // Non-minimal length encodings are legal, so mix them in
   function automatic len_enc_type pick_enc(logic [63:0] len);
      int unsigned r;
      if (len > 65535) return ENC_64;
      if (len > 125) return ($urandom_range(0, 3) == 0) ? ENC_64 : ENC_16;
      r = $urandom_range(0, 9);
      if (r < 7) return ENC_SHORT;
      if (r < 9) return ENC_16;
      return ENC_64;
   endfunction

   // Receiver side: random holds, plus one long hold on request
   initial begin : rsp_side
      int unsigned busy_left;
      int unsigned free_left;
      busy_left = 0;
      free_left = 0;
      holding = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            holding = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding = 0;
         end
         if (busy_left != 0) begin
            busy_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (free_left != 0) free_left--;
            else begin
               busy_left = pick_gap();
               free_left = $urandom_range(0, 12);
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [63:0] len, input len_enc_type enc);
      logic [2:0] rsv;
      int         i;
      rsv = 3'($urandom_range(0, 7));
      send_byte({fin, rsv, op});
      case (enc)
         ENC_SHORT: send_byte({masked, len[6:0]});
         ENC_16: begin
            send_byte({masked, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LEN_EXT64});
            for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
         end
      endcase
      if (masked) repeat (4) send_byte(pick_payload());
   endtask

   task automatic drive_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [63:0] len, input len_enc_type enc);
      send_header(fin, op, masked, len, enc);
      repeat (len) send_byte(pick_payload());
   endtask

   task automatic drive_frame_any(input logic fin, input logic [3:0] op,
                                  input logic [63:0] len);
      drive_frame(fin, op, $urandom_range(0, 3) != 0, len, pick_enc(len));
   endtask

   task automatic send_control();
      drive_frame_any(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? OP_PING : OP_PONG,
                      pick_len());
   endtask

   // One data message, maybe fragmented, with pings and pongs between fragments
   task automatic send_message();
      int unsigned nfrag;
      int unsigned i;
      logic [3:0]  op;
      nfrag = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 5) : 1;
      op = $urandom_range(0, 1) ? OP_BINARY : OP_TEXT;
      for (i = 0; i < nfrag; i++) begin
         if (i != 0 && $urandom_range(0, 3) == 0) send_control();
         drive_frame_any(i == nfrag - 1, (i == 0) ? op : OP_CONT, pick_len());
      end
   endtask

   task automatic send_unit();
      no_gaps = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 7) send_message();
      else send_control();
   endtask

   // Drop valid and wait until every outstanding result has been taken
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || hold_req || holding) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [63:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_MAX_LEN;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== v) begin
         $error("max_frame_length: expected %0d, got %0d", v, csr_prdata);
         sb.faults++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_limit(v);
      limit_now = v;
      limit_writes++;
   endtask

   initial begin : stimulus
      int unsigned ph;
      int unsigned target;
      logic [63:0] lim;
      logic [63:0] len;
      logic [3:0]  op;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = ADDR_MAX_LEN;
      csr_pwdata = 64'd0;
      limit_now = MAX_LEN_RESET;
      bytes_sent = 0;
      limit_writes = 0;
      no_gaps = 0;
      hold_req = 0;
      ending = END_CLOSE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      drive_frame(1, OP_TEXT, 0, 0, ENC_SHORT);     // empty frame ends a whole message
      drive_frame(1, OP_BINARY, 1, 2, ENC_SHORT);
      drive_frame(0, OP_TEXT, 0, 1, ENC_16);        // open a fragmented text message
      drive_frame(1, OP_PONG, 0, 0, ENC_SHORT);     // empty pong gives nothing
      drive_frame(0, OP_PING, 0, 0, ENC_SHORT);     // ping inside the message, FIN ignored
      drive_frame(1, OP_PONG, 0, 1, ENC_SHORT);     // pong payload is swallowed
      drive_frame(1, OP_CONT, 0, 0, ENC_SHORT);     // empty final fragment closes the message
      settle();

      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: lim = 64'd0;
            1: lim = '1;
            2: lim = {$urandom, $urandom};
            3: lim = 64'($urandom_range(0, 40));
            default: lim = 64'($urandom_range(1, 200));
         endcase
         write_limit(lim);
         if (ph == 1) begin
            // long receiver hold while the sender keeps pushing
            no_gaps = 1;
            hold_req = 1;
            drive_frame(1, OP_BINARY, 1'($urandom_range(0, 1)), 200, ENC_16);
         end
         target = bytes_sent + ((ph == 0) ? 60 : 260);
         while (bytes_sent < target) send_unit();
         settle();
      end

      // The block halts for good after this, so only one ending per run
      ending = end_kind_type'($urandom_range(0, 4));
      no_gaps = 0;
      case (ending)
         END_CLOSE: begin
            if ($urandom_range(0, 1)) drive_frame_any(0, OP_TEXT, pick_len());
            drive_frame_any(1'($urandom_range(0, 1)), OP_CLOSE, pick_len());
         end
         END_STRAY: begin
            len = pick_len();
            send_header(1'($urandom_range(0, 1)), OP_CONT, 1'($urandom_range(0, 1)), len,
                        pick_enc(len));
         end
         END_MID_FRAG: begin
            drive_frame_any(0, OP_BINARY, pick_len());
            len = pick_len();
            send_header(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
                        1'($urandom_range(0, 1)), len, pick_enc(len));
         end
         END_OPCODE: begin
            op = 4'($urandom_range(3, 12));
            if (op >= OP_CLOSE) op = op + 4'd3;
            len = pick_len();
            send_header(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)), len,
                        pick_enc(len));
         end
         default: begin
            // size wins over any opcode
            len = $urandom_range(0, 1) ? limit_now + 64'd1 : '1;
            op = 4'($urandom_range(0, 15));
            send_header(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)), len,
                        pick_enc(len));
         end
      endcase
      // everything from here on is dropped by the halted block
      repeat ($urandom_range(10, 30)) send_byte(8'($urandom_range(0, 255)));
      settle();

      $display("sent %0d stream bytes over %0d limit settings; checked %0d results",
               bytes_sent, limit_writes, sb.results);
      $display("%0d payload bytes, %0d markers, %0d errors; run ended with %s",
               sb.payload_seen, sb.markers_seen, sb.errors_seen, ending.name());
      if (sb.faults == 0 && sb.pending() == 0) begin
         $display("websocket_frame_receiver_tb passed");
      end else begin
         $display("websocket_frame_receiver_tb failed");
      end
      $finish;
   end

endmodule
